// ----- sv/im2col_pkg.sv -----
`default_nettype none

package im2col_pkg;

  // Default sizes of the image store.
  localparam int IMAGE_WORDS_DEFAULT = 16384;
  localparam int DATA_WIDTH_DEFAULT  = 32;

  // Largest image height or width that is honored; larger settings are clamped.
  localparam int MAX_DIM = 64;

  // Fixed field widths.
  localparam int ADDR_W    = 14;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDES       = 4'd7;

  // Reset values of the configuration registers.
  localparam logic [4:0] CHANNELS_RST = 5'd1;
  localparam logic [6:0] DIM_RST      = 7'd1;
  localparam logic [3:0] KERNEL_RST   = 4'd1;
  localparam logic [3:0] PAD_RST      = 4'd0;
  localparam logic [7:0] STRIDES_RST  = 8'h11;

  // Flags of an item held between the address stage and the result register.
  typedef struct packed {
    logic valid;
    logic use_mem;
    logic pad;
    logic last;
    logic err;
  } stage_t;

endpackage

`default_nettype wire

// ----- sv/im2col_ifs.sv -----
`default_nettype none

interface im2col_item_if;
  import im2col_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] load_address;
  logic [WORD_W-1:0] load_word;
  modport source (output valid, cmd, load_address, load_word, input ready);
  modport sink   (input valid, cmd, load_address, load_word, output ready);
endinterface

interface im2col_result_if;
  import im2col_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] column_word;
  logic              is_padding;
  logic              last;
  logic              error;
  modport source (output valid, column_word, is_padding, last, error, input ready);
  modport sink   (input valid, column_word, is_padding, last, error, output ready);
endinterface

interface im2col_cfg_if;
  import im2col_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/im2col_column_generator.sv -----
`default_nettype none

// Channel  Direction  Transaction
// cfg      in         register write: index, data
// item     in         load (address, word) or emit command
// result   out        column_word, is_padding, last, error
//
// One item is accepted per cycle while item.ready is high; its result passes through the
// address stage, with the synchronous read of the image store, and then the result register.
// Reset restores configuration defaults and the sequence position; the image store is kept.
// When result.ready is low the result holds, and item.ready drops once the
// address stage is also full.
module im2col_column_generator #(
  parameter int IMAGE_WORDS = im2col_pkg::IMAGE_WORDS_DEFAULT,
  parameter int DATA_WIDTH  = im2col_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire             clk,
  input  wire             rst,
  im2col_cfg_if.sink      cfg,
  im2col_item_if.sink     item,
  im2col_result_if.source result
);
  import im2col_pkg::*;

  localparam int MEM_AW = (IMAGE_WORDS > 1) ? $clog2(IMAGE_WORDS) : 1;

  // Configuration registers.
  logic [4:0] channels;
  logic [6:0] image_height;
  logic [6:0] image_width;
  logic [3:0] kernel_height;
  logic [3:0] kernel_width;
  logic [3:0] pad_rows;
  logic [3:0] pad_cols;
  logic [7:0] strides;

  // Sequence position.
  logic [3:0]        channel_index;
  logic [18:0]       channel_base;
  logic [3:0]        kernel_row_index;
  logic [3:0]        kernel_col_index;
  logic signed [7:0] source_row;
  logic signed [7:0] source_col;

  // Effective (clamped) settings.
  logic [4:0] ch_eff;
  logic [6:0] h_eff;
  logic [6:0] w_eff;
  logic [3:0] kh_eff;
  logic [3:0] kw_eff;
  logic [3:0] sh_eff;
  logic [3:0] sw_eff;
  logic [13:0] plane;
  logic [18:0] load_limit;

  always_comb begin
    ch_eff = (channels == 5'd0) ? 5'd1 : ((channels > 5'd16) ? 5'd16 : channels);
    h_eff  = (image_height == 7'd0) ? 7'd1 :
             ((32'(image_height) > MAX_DIM) ? 7'(MAX_DIM) : image_height);
    w_eff  = (image_width == 7'd0) ? 7'd1 :
             ((32'(image_width) > MAX_DIM) ? 7'(MAX_DIM) : image_width);
    kh_eff = (kernel_height == 4'd0) ? 4'd1 : kernel_height;
    kw_eff = (kernel_width == 4'd0) ? 4'd1 : kernel_width;
    sh_eff = (strides[7:4] == 4'd0) ? 4'd1 : strides[7:4];
    sw_eff = (strides[3:0] == 4'd0) ? 4'd1 : strides[3:0];
    plane      = 14'(h_eff) * 14'(w_eff);
    load_limit = 19'(plane) * 19'(ch_eff);
  end

  // Handshake and pipeline control.
  stage_t s1;
  logic   s1_move;
  logic   item_acc;
  logic   load_acc;
  logic   emit_acc;

  assign s1_move    = s1.valid && (!result.valid || result.ready);
  assign item.ready = !s1.valid || s1_move;
  assign item_acc   = item.valid && item.ready;
  assign load_acc   = item_acc && (item.cmd == CMD_LOAD);
  assign emit_acc   = item_acc && (item.cmd == CMD_EMIT);
  assign cfg.ready  = 1'b1;

  // Load checks.
  logic load_ok;
  assign load_ok = (19'(item.load_address) < load_limit) &&
                   (32'(item.load_address) < 32'(IMAGE_WORDS));

  // Emit position logic.
  logic              kernel_too_big;
  logic              in_image;
  logic [19:0]       emit_addr;
  logic              emit_addr_ok;
  logic signed [9:0] col_probe;
  logic signed [9:0] row_probe;
  logic signed [9:0] col_bound;
  logic signed [9:0] row_bound;
  logic              col_step;
  logic              row_step;
  logic [4:0]        kc_inc;
  logic [4:0]        kr_inc;
  logic [4:0]        ch_inc;
  logic              kc_wrap;
  logic              kr_wrap;
  logic              ch_wrap;
  logic [3:0]        kc_new;
  logic [3:0]        kr_new;

  always_comb begin
    kernel_too_big = (8'(kh_eff) > 8'(h_eff) + 8'({pad_rows, 1'b0})) ||
                     (8'(kw_eff) > 8'(w_eff) + 8'({pad_cols, 1'b0}));
    in_image = (source_row >= 8'sd0) && (10'(source_row) < $signed(10'(h_eff))) &&
               (source_col >= 8'sd0) && (10'(source_col) < $signed(10'(w_eff)));
    emit_addr = 20'(channel_base) + 20'(source_row[6:0]) * 20'(w_eff) +
                20'(source_col[6:0]);
    emit_addr_ok = 32'(emit_addr) < 32'(IMAGE_WORDS);

    // The next window position exists while the window still ends inside
    // the padded image.
    col_probe = 10'(source_col) + $signed(10'(sw_eff)) - $signed(10'(kernel_col_index))
                + $signed(10'(kw_eff));
    row_probe = 10'(source_row) + $signed(10'(sh_eff)) - $signed(10'(kernel_row_index))
                + $signed(10'(kh_eff));
    col_bound = $signed(10'(w_eff)) + $signed(10'(pad_cols));
    row_bound = $signed(10'(h_eff)) + $signed(10'(pad_rows));
    col_step  = col_probe <= col_bound;
    row_step  = row_probe <= row_bound;

    kc_inc  = 5'(kernel_col_index) + 5'd1;
    kc_wrap = kc_inc >= 5'(kw_eff);
    kr_inc  = 5'(kernel_row_index) + (kc_wrap ? 5'd1 : 5'd0);
    kr_wrap = kc_wrap && (kr_inc >= 5'(kh_eff));
    ch_inc  = 5'(channel_index) + 5'd1;
    ch_wrap = kr_wrap && (ch_inc >= ch_eff);
    kc_new  = kc_wrap ? 4'd0 : kc_inc[3:0];
    kr_new  = kr_wrap ? 4'd0 : kr_inc[3:0];
  end

  // Pad values after a configuration write, for the restart.
  logic [3:0] pad_rows_next;
  logic [3:0] pad_cols_next;
  logic       cfg_hit;

  always_comb begin
    pad_rows_next = (cfg.index == REG_PAD_ROWS) ? cfg.data[3:0] : pad_rows;
    pad_cols_next = (cfg.index == REG_PAD_COLS) ? cfg.data[3:0] : pad_cols;
    cfg_hit       = cfg.valid && (cfg.index <= REG_STRIDES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channels         <= CHANNELS_RST;
      image_height     <= DIM_RST;
      image_width      <= DIM_RST;
      kernel_height    <= KERNEL_RST;
      kernel_width     <= KERNEL_RST;
      pad_rows         <= PAD_RST;
      pad_cols         <= PAD_RST;
      strides          <= STRIDES_RST;
      channel_index    <= '0;
      channel_base     <= '0;
      kernel_row_index <= '0;
      kernel_col_index <= '0;
      source_row       <= '0;
      source_col       <= '0;
    end else if (cfg_hit) begin
      unique case (cfg.index)
        REG_CHANNELS:      channels      <= cfg.data[4:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg.data[6:0];
        REG_IMAGE_WIDTH:   image_width   <= cfg.data[6:0];
        REG_KERNEL_HEIGHT: kernel_height <= cfg.data[3:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg.data[3:0];
        REG_PAD_ROWS:      pad_rows      <= cfg.data[3:0];
        REG_PAD_COLS:      pad_cols      <= cfg.data[3:0];
        REG_STRIDES:       strides       <= cfg.data;
        default: ;
      endcase
      channel_index    <= '0;
      channel_base     <= '0;
      kernel_row_index <= '0;
      kernel_col_index <= '0;
      source_row       <= -$signed(8'(pad_rows_next));
      source_col       <= -$signed(8'(pad_cols_next));
    end else if (emit_acc && !kernel_too_big) begin
      if (col_step) begin
        source_col <= source_col + $signed(8'(sw_eff));
      end else if (row_step) begin
        source_row <= source_row + $signed(8'(sh_eff));
        source_col <= $signed(8'(kernel_col_index)) - $signed(8'(pad_cols));
      end else begin
        kernel_col_index <= kc_new;
        kernel_row_index <= kr_new;
        source_row       <= $signed(8'(kr_new)) - $signed(8'(pad_rows));
        source_col       <= $signed(8'(kc_new)) - $signed(8'(pad_cols));
        if (kr_wrap) begin
          if (ch_wrap) begin
            channel_index <= '0;
            channel_base  <= '0;
          end else begin
            channel_index <= ch_inc[3:0];
            channel_base  <= channel_base + 19'(plane);
          end
        end
      end
    end
  end

  // Image store: one write port for loads, one registered read port for emits.
  logic [DATA_WIDTH-1:0] image_store [IMAGE_WORDS];
  logic [DATA_WIDTH-1:0] mem_q;
  logic                  rd_en;

  assign rd_en = emit_acc && !kernel_too_big && in_image && emit_addr_ok;

  always_ff @(posedge clk) begin
    if (load_acc && load_ok) begin
      image_store[MEM_AW'(item.load_address)] <= DATA_WIDTH'(item.load_word);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= image_store[MEM_AW'(emit_addr)];
    end
  end

  // Address stage flags.
  stage_t s1_next;

  always_comb begin
    s1_next = s1;
    if (item_acc) begin
      s1_next.valid   = 1'b1;
      s1_next.use_mem = rd_en;
      s1_next.pad     = emit_acc && !kernel_too_big && !in_image;
      s1_next.last    = emit_acc && !kernel_too_big && !col_step && !row_step && ch_wrap;
      s1_next.err     = load_acc ? !load_ok : kernel_too_big;
    end else if (s1_move) begin
      s1_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= s1_next.valid;
    end
    s1.use_mem <= s1_next.use_mem;
    s1.pad     <= s1_next.pad;
    s1.last    <= s1_next.last;
    s1.err     <= s1_next.err;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_move) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (s1_move) begin
      result.column_word <= s1.use_mem ? WORD_W'(mem_q) : '0;
      result.is_padding  <= s1.pad;
      result.last        <= s1.last;
      result.error       <= s1.err;
    end
  end

`ifndef SYNTHESIS
  a_pad_is_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.is_padding |-> result.column_word == '0)
    else $error("padding result carries a nonzero word");

  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.error |-> !result.is_padding && !result.last)
    else $error("error result also flags padding or last");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1.valid && !s1_move |=> s1.valid)
    else $error("stalled item dropped from the address stage");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> 5'(channel_index) < ch_eff || $past(cfg_hit))
    else $error("channel index beyond the configured channel count");
`endif

endmodule

`default_nettype wire
